[rtl/core/stok_pkg.sv]
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and constants for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned CHAR_W       = 7;
  localparam int unsigned OUT_POS_W    = 16;
  localparam int unsigned OUT_LEN_W    = 16;
  // result queue depth, at least two so one character's tokens fit at once
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    KIND_INT     = 3'd0,
    KIND_FLOAT   = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_CHAR    = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_END     = 3'd6,
    KIND_INVALID = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_INT_DOT,
    MODE_IDENT,
    MODE_QUOTE,
    MODE_PUNCT
  } mode_e;

  typedef struct packed {
    kind_e                 kind;
    logic [OUT_POS_W-1:0]  start;
    logic [OUT_LEN_W-1:0]  len;
    logic                  last;
  } token_t;

  // tokens produced by one character, already compacted into r0 then r1
  typedef struct packed {
    logic [1:0] count;
    token_t     r0;
    token_t     r1;
  } push_t;

endpackage

[rtl/core/source_tokenizer.sv]
// A character waits in the input register until the queue has room; the
// scanner update then writes its tokens into the result queue. Throughput:
// one character per cycle while the queue has room; a character that closes
// two tokens leaves them one per output transaction, absorbed by the
// four-entry result queue. The rate is set by the scanner update between input
// register and result queue. Reset: scanner idle at position zero, queue empty.
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one character per transaction in, tokens out.
// ----------------------------------------------------------------------------
module source_tokenizer #(
  parameter int unsigned PosBits = stok_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [stok_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                            end_of_source_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      token_kind_o,
  output logic [stok_pkg::OUT_POS_W-1:0]  start_pos_o,
  output logic [stok_pkg::OUT_LEN_W-1:0]  text_length_o,
  output logic                            last_o
);
  import stok_pkg::*;

  logic              in_vld_q;
  logic [CHAR_W-1:0] char_q;
  logic              eos_q;
  logic              room;
  logic              fire;
  push_t             push;
  token_t            head;

  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      eos_q  <= end_of_source_i;
    end
  end

  stok_step #(
    .PosBits(PosBits)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .eos_i  (eos_q),
    .push_o (push)
  );

  stok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign token_kind_o  = head.kind;
  assign start_pos_o   = head.start;
  assign text_length_o = head.len;
  assign last_o        = head.last;

endmodule

[rtl/core/stok_step.sv]
// ----------------------------------------------------------------------------
// stok_step
// Scanner state and per-character next-state / token logic.
// ----------------------------------------------------------------------------
module stok_step #(
  parameter int unsigned PosBits = stok_pkg::POS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [stok_pkg::CHAR_W-1:0]   char_i,
  input  logic                          eos_i,
  output stok_pkg::push_t               push_o
);
  import stok_pkg::*;

  localparam logic [CHAR_W-1:0] CH_DQ  = 7'h22;
  localparam logic [CHAR_W-1:0] CH_SQ  = 7'h27;
  localparam logic [CHAR_W-1:0] CH_DOT = 7'h2e;
  localparam logic [CHAR_W-1:0] CH_EQ  = 7'h3d;
  localparam logic [CHAR_W-1:0] CH_LT  = 7'h3c;
  localparam logic [CHAR_W-1:0] CH_GT  = 7'h3e;
  localparam logic [CHAR_W-1:0] CH_SP  = 7'h20;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 7'h30) && (c <= 7'h39);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 7'h61) && (c <= 7'h7a)) || ((c >= 7'h41) && (c <= 7'h5a)) ||
           (c == 7'h5f);
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || ((c >= 7'h09) && (c <= 7'h0d));
  endfunction

  // ( ) { } [ ] < > + - * / % = & ^ | ~ : ; , . ! ?
  function automatic logic is_single(input logic [CHAR_W-1:0] c);
    return c inside {7'h28, 7'h29, 7'h7b, 7'h7d, 7'h5b, 7'h5d, 7'h3c, 7'h3e,
                     7'h2b, 7'h2d, 7'h2a, 7'h2f, 7'h25, 7'h3d, 7'h26, 7'h5e,
                     7'h7c, 7'h7e, 7'h3a, 7'h3b, 7'h2c, 7'h2e, 7'h21, 7'h3f};
  endfunction

  // first characters of two-character punctuators: > < + - * / % & |
  function automatic logic is_prefix(input logic [CHAR_W-1:0] c);
    return c inside {7'h3e, 7'h3c, 7'h2b, 7'h2d, 7'h2a, 7'h2f, 7'h25, 7'h26, 7'h7c};
  endfunction

  function automatic logic is_pair(input logic [CHAR_W-1:0] a,
                                   input logic [CHAR_W-1:0] b);
    logic r;
    r = 1'b0;
    case (a)
      7'h3e, 7'h3c: r = (b == CH_EQ) || (b == a);            // >= >> <= <<
      7'h2b:        r = (b == CH_EQ) || (b == 7'h2b);         // += ++
      7'h2d:        r = (b == CH_EQ) || (b == 7'h2d) || (b == CH_GT); // -= -- ->
      7'h2a, 7'h2f, 7'h25: r = (b == CH_EQ);                  // *= /= %=
      7'h26:        r = (b == 7'h26);                         // &&
      7'h7c:        r = (b == 7'h7c);                         // ||
      default:      r = 1'b0;
    endcase
    return r;
  endfunction

  mode_e               mode_q, mode_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic [PosBits-1:0]  start_q, start_d;
  logic [CHAR_W-1:0]   first_q, first_d;
  logic                two_q, two_d;
  logic                dq_q, dq_d;

  logic [PosBits-1:0]  span_p, span_q, dot_pos, span_dot;
  token_t              a_tok, b_tok;
  logic                a_vld, b_vld;
  logic                do_begin;

  // start of a new token with the current character
  mode_e               bg_mode;
  logic                bg_vld;
  kind_e               bg_kind;

  assign span_p   = pos_q - start_q;
  assign span_q   = span_p - PosBits'(1);
  assign dot_pos  = pos_q - PosBits'(1);
  assign span_dot = dot_pos - start_q;

  always_comb begin
    bg_mode = MODE_IDLE;
    bg_vld  = 1'b0;
    bg_kind = KIND_INVALID;
    if (is_space(char_i)) begin
      bg_mode = MODE_IDLE;
    end else if (is_digit(char_i)) begin
      bg_mode = MODE_INT;
    end else if (is_alpha(char_i)) begin
      bg_mode = MODE_IDENT;
    end else if ((char_i == CH_DQ) || (char_i == CH_SQ)) begin
      bg_mode = MODE_QUOTE;
    end else if (is_prefix(char_i)) begin
      bg_mode = MODE_PUNCT;
    end else if (is_single(char_i)) begin
      bg_vld  = 1'b1;
      bg_kind = KIND_PUNCT;
    end else begin
      bg_vld  = 1'b1;
      bg_kind = KIND_INVALID;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    first_d  = first_q;
    two_d    = two_q;
    dq_d     = dq_q;
    a_vld    = 1'b0;
    b_vld    = 1'b0;
    a_tok    = '{kind: KIND_INT, start: OUT_POS_W'(start_q), len: OUT_LEN_W'(span_p),
                 last: 1'b0};
    b_tok    = '{kind: KIND_END, start: OUT_POS_W'(pos_q), len: '0, last: 1'b0};
    do_begin = 1'b0;

    if (eos_i) begin
      unique case (mode_q)
        MODE_INT: begin
          a_vld = 1'b1;
        end
        MODE_INT_DOT: begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_FLOAT;
        end
        MODE_IDENT: begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_IDENT;
        end
        MODE_QUOTE: begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_INVALID;
        end
        MODE_PUNCT: begin
          a_vld      = 1'b1;
          a_tok.kind = KIND_PUNCT;
          a_tok.len  = two_q ? OUT_LEN_W'(2) : OUT_LEN_W'(1);
        end
        default: a_vld = 1'b0;
      endcase
      b_vld   = 1'b1;
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      two_d   = 1'b0;
      first_d = '0;
    end else begin
      pos_d = pos_q + PosBits'(1);
      unique case (mode_q)
        MODE_INT: begin
          if (is_digit(char_i)) begin
            mode_d = MODE_INT;
          end else if (char_i == CH_DOT) begin
            mode_d = MODE_INT_DOT;
          end else begin
            a_vld    = 1'b1;
            do_begin = 1'b1;
          end
        end
        MODE_INT_DOT: begin
          a_vld    = 1'b1;
          do_begin = 1'b1;
          if (char_i <= CH_SP) begin
            a_tok.kind = KIND_FLOAT;
          end else if (is_alpha(char_i)) begin
            // dot split off the integer as its own punctuator
            a_tok.len = OUT_LEN_W'(span_dot);
            b_vld     = 1'b1;
            b_tok     = '{kind: KIND_PUNCT, start: OUT_POS_W'(dot_pos),
                          len: OUT_LEN_W'(1), last: 1'b0};
          end
        end
        MODE_IDENT: begin
          if (!(is_alpha(char_i) || is_digit(char_i))) begin
            a_vld      = 1'b1;
            a_tok.kind = KIND_IDENT;
            do_begin   = 1'b1;
          end
        end
        MODE_QUOTE: begin
          if (char_i == (dq_q ? CH_DQ : CH_SQ)) begin
            a_vld      = 1'b1;
            a_tok.kind = dq_q ? KIND_STRING : KIND_CHAR;
            a_tok.len  = OUT_LEN_W'(span_q);
            mode_d     = MODE_IDLE;
          end
        end
        MODE_PUNCT: begin
          a_tok.kind = KIND_PUNCT;
          if (two_q) begin
            a_vld = 1'b1;
            two_d = 1'b0;
            if (char_i == CH_EQ) begin
              a_tok.len = OUT_LEN_W'(3);
              mode_d    = MODE_IDLE;
            end else begin
              a_tok.len = OUT_LEN_W'(2);
              do_begin  = 1'b1;
            end
          end else if (is_pair(first_q, char_i)) begin
            if (((first_q == CH_GT) || (first_q == CH_LT)) && (char_i == first_q)) begin
              two_d = 1'b1;
            end else begin
              a_vld     = 1'b1;
              a_tok.len = OUT_LEN_W'(2);
              mode_d    = MODE_IDLE;
            end
          end else begin
            a_vld     = 1'b1;
            a_tok.len = OUT_LEN_W'(1);
            do_begin  = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase

      if (do_begin) begin
        mode_d  = bg_mode;
        start_d = pos_q;
        two_d   = 1'b0;
        if (bg_mode == MODE_QUOTE) begin
          dq_d = (char_i == CH_DQ);
        end
        if (bg_mode == MODE_PUNCT) begin
          first_d = char_i;
        end
        if (bg_vld) begin
          b_vld = 1'b1;
          b_tok = '{kind: bg_kind, start: OUT_POS_W'(pos_q), len: OUT_LEN_W'(1),
                    last: 1'b0};
        end
      end
    end
  end

  // compact the two slots and mark the final token of this character
  always_comb begin
    push_o = '0;
    if (a_vld) begin
      push_o.r0      = a_tok;
      push_o.r1      = b_tok;
      push_o.r0.last = !b_vld;
      push_o.r1.last = 1'b1;
      push_o.count   = b_vld ? 2'd2 : 2'd1;
    end else begin
      push_o.r0      = b_tok;
      push_o.r0.last = 1'b1;
      push_o.r1      = b_tok;
      push_o.count   = b_vld ? 2'd1 : 2'd0;
    end
    if (!fire_i) begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      first_q <= '0;
      two_q   <= 1'b0;
      dq_q    <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      first_q <= first_d;
      two_q   <= two_d;
      dq_q    <= dq_d;
    end
  end

endmodule

[rtl/core/stok_queue.sv]
// ----------------------------------------------------------------------------
// stok_queue
// Result queue taking up to two tokens per cycle, one out per transaction.
// ----------------------------------------------------------------------------
module stok_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stok_pkg::push_t      push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output stok_pkg::token_t     head_o
);
  import stok_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  token_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;
  logic [PtrW-1:0]   wr_next;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // room for the worst case of two tokens from one character
  assign room_o  = (cnt_q <= CntW'(QUEUE_DEPTH - 2));
  assign wr_next = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.count);
    rd_d  = pop ? (rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
